@@ rtl/core/owbl_pkg.sv @@
package owbl_pkg;

   // Segment duration width, microseconds
   localparam int DUR_W = 10;
   localparam int CSR_IDX_W = 3;
   localparam int LEVEL_W = 8;
   localparam int LEVEL_BITS_DEF = 8;

   typedef enum logic [1:0] {
      OP_UPDATE  = 2'd0,
      OP_SUSPEND = 2'd1,
      OP_RESUME  = 2'd2,
      OP_RSVD    = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_HIGH = 3'd0,
      CSR_ZERO_LOW   = 3'd1,
      CSR_ZERO_HIGH  = 3'd2,
      CSR_ONE_LOW    = 3'd3,
      CSR_ONE_HIGH   = 3'd4,
      CSR_END_LOW    = 3'd5,
      CSR_END_HIGH   = 3'd6,
      CSR_NONE       = 3'd7
   } csr_index_type;

   localparam logic [DUR_W-1:0] RST_START_HIGH = DUR_W'(40);
   localparam logic [DUR_W-1:0] RST_ZERO_LOW   = DUR_W'(40);
   localparam logic [DUR_W-1:0] RST_ZERO_HIGH  = DUR_W'(10);
   localparam logic [DUR_W-1:0] RST_ONE_LOW    = DUR_W'(10);
   localparam logic [DUR_W-1:0] RST_ONE_HIGH   = DUR_W'(40);
   localparam logic [DUR_W-1:0] RST_END_LOW    = DUR_W'(10);
   localparam logic [DUR_W-1:0] RST_END_HIGH   = DUR_W'(400);

   // Fixed enable sequence sent ahead of a resume
   localparam logic [DUR_W-1:0] EN_HIGH1_US = DUR_W'(200);
   localparam logic [DUR_W-1:0] EN_LOW_US   = DUR_W'(300);
   localparam logic [DUR_W-1:0] EN_HIGH2_US = DUR_W'(400);

   // Steps 0..2 are the enable sequence; a level frame starts at this step
   localparam int FRAME_FIRST_STEP = 3;

   typedef struct packed {
      logic [DUR_W-1:0] start_high;
      logic [DUR_W-1:0] zero_low;
      logic [DUR_W-1:0] zero_high;
      logic [DUR_W-1:0] one_low;
      logic [DUR_W-1:0] one_high;
      logic [DUR_W-1:0] end_low;
      logic [DUR_W-1:0] end_high;
   } timing_type;

   typedef struct packed {
      logic             pin;
      logic [DUR_W-1:0] dur;
      logic             last;
   } seg_type;

endpackage

@@ rtl/core/owbl_seg_gen.sv @@
module owbl_seg_gen
   import owbl_pkg::*;
#(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF,
   parameter int STEP_W = 4
) (
   input  timing_type              timing,
   input  logic                    suspend,
   input  logic [STEP_W-1:0]       step,
   input  logic [LEVEL_BITS-1:0]   level,
   output seg_type                 seg
);

   localparam int BIT_W = (LEVEL_BITS > 1) ? $clog2(LEVEL_BITS) : 1;
   localparam logic [STEP_W-1:0] END_LOW_U  = STEP_W'(2 * LEVEL_BITS + 1);
   localparam logic [STEP_W-1:0] END_HIGH_U = STEP_W'(2 * LEVEL_BITS + 2);

   // level reordered so index 0 is the MSB, sent first
   logic [LEVEL_BITS-1:0] lvl_msb;

   genvar gi;
   generate
      for (gi = 0; gi < LEVEL_BITS; gi++) begin : g_rev
         assign lvl_msb[gi] = level[LEVEL_BITS-1-gi];
      end
   endgenerate

   logic [STEP_W-1:0] u;
   logic [STEP_W-1:0] d;
   logic [STEP_W-1:0] dh;
   logic [BIT_W-1:0]  k;
   logic              bit_val;

   always_comb begin
      u       = step - STEP_W'(FRAME_FIRST_STEP);
      d       = u - STEP_W'(1);
      dh      = d >> 1;
      k       = dh[BIT_W-1:0];
      bit_val = lvl_msb[k];
      seg     = '0;
      if (suspend) begin
         // line held low indefinitely
         seg.pin  = 1'b0;
         seg.dur  = '0;
         seg.last = 1'b1;
      end else if (step == STEP_W'(0)) begin
         seg.pin = 1'b1;
         seg.dur = EN_HIGH1_US;
      end else if (step == STEP_W'(1)) begin
         seg.pin = 1'b0;
         seg.dur = EN_LOW_US;
      end else if (step == STEP_W'(2)) begin
         seg.pin = 1'b1;
         seg.dur = EN_HIGH2_US;
      end else if (u == STEP_W'(0)) begin
         seg.pin = 1'b1;
         seg.dur = timing.start_high;
      end else if (u == END_LOW_U) begin
         seg.pin = 1'b0;
         seg.dur = timing.end_low;
      end else if (u == END_HIGH_U) begin
         seg.pin  = 1'b1;
         seg.dur  = timing.end_high;
         seg.last = 1'b1;
      end else begin
         // data bit: even d is the low phase, odd d the high phase
         seg.pin = d[0];
         if (bit_val) begin
            seg.dur = d[0] ? timing.one_high : timing.one_low;
         end else begin
            seg.dur = d[0] ? timing.zero_high : timing.zero_low;
         end
      end
   end

endmodule

@@ rtl/core/one_wire_backlight_level_sender_core.sv @@
// Single-wire pulse-width backlight level sender.
// req channel: one command beat (update, suspend, resume) with the level and
// panel status flags. rsp channel: one beat per waveform segment, giving the
// pin level and its duration in microseconds (0 = hold), the level now held
// by the panel, and last on the final segment of the command.
// csr port: single-cycle writes of the seven segment timings, index 0..6.
// An accepted beat loads the command register and stepper; each segment then
// passes to the output register. Segments leave one per cycle while
// rsp_ready is high. An update sends 2*LEVEL_BITS+3 segments (19 for 8 bits),
// a resume 2*LEVEL_BITS+6 (22), a suspend 1, produced by the segment stepper
// at one segment per cycle while the output can load. Updates while disabled
// and reserved codes produce nothing. The next command is taken in the same
// cycle the last segment of the current one moves to the output register.
// Reset: updates enabled, held level 0, timings at defaults, no beats pending.
// On a receiver stall the output register holds its segment and the stepper
// and command register freeze; req_ready is low while a command is in the
// stepper except as its last segment loads; an idle stepper still takes one beat.
module one_wire_backlight_level_sender_core
   import owbl_pkg::*;
#(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [LEVEL_W-1:0]    req_level,
   input  logic                  req_powered,
   input  logic                  req_unblanked,
   input  logic                  req_core_suspended,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_pin_level,
   output logic [DUR_W-1:0]      rsp_duration_us,
   output logic [LEVEL_W-1:0]    rsp_sent_level,
   output logic                  rsp_last,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DUR_W-1:0]      csr_wdata
);

   localparam int STEP_W = $clog2(2 * LEVEL_BITS + 6);

   // ---------------- timing registers ----------------
   timing_type timing_ff, timing_in;

   always_comb begin
      timing_in = timing_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_HIGH: timing_in.start_high = csr_wdata;
            CSR_ZERO_LOW:   timing_in.zero_low   = csr_wdata;
            CSR_ZERO_HIGH:  timing_in.zero_high  = csr_wdata;
            CSR_ONE_LOW:    timing_in.one_low    = csr_wdata;
            CSR_ONE_HIGH:   timing_in.one_high   = csr_wdata;
            CSR_END_LOW:    timing_in.end_low    = csr_wdata;
            CSR_END_HIGH:   timing_in.end_high   = csr_wdata;
            default:        timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff <= '{start_high: RST_START_HIGH, zero_low: RST_ZERO_LOW,
                        zero_high: RST_ZERO_HIGH, one_low: RST_ONE_LOW,
                        one_high: RST_ONE_HIGH, end_low: RST_END_LOW,
                        end_high: RST_END_HIGH};
      end else begin
         timing_ff <= timing_in;
      end
   end

   // ---------------- command decode ----------------
   opcode_type op;
   logic       accept;
   logic       emits;
   logic       frame_cmd;     // command that sends a level frame
   logic [LEVEL_BITS-1:0] lvl_eff;
   logic [LEVEL_W-1:0]    lvl_sent8;

   assign op        = opcode_type'(req_opcode);
   assign accept    = req_valid && req_ready;

   logic enabled_ff, enabled_in;
   logic [LEVEL_W-1:0] sent_ff, sent_in;

   assign frame_cmd = (op == OP_RESUME) || ((op == OP_UPDATE) && enabled_ff);
   assign emits     = frame_cmd || (op == OP_SUSPEND);

   // forced to zero unless powered, unblanked and core awake; masked to width
   genvar gi;
   generate
      for (gi = 0; gi < LEVEL_BITS; gi++) begin : g_lvl
         if (gi < LEVEL_W) begin : g_in
            assign lvl_eff[gi] = req_level[gi] && req_powered && req_unblanked
                                 && !req_core_suspended;
         end else begin : g_zero
            assign lvl_eff[gi] = 1'b0;
         end
      end
      for (gi = 0; gi < LEVEL_W; gi++) begin : g_sent
         if (gi < LEVEL_BITS) begin : g_bit
            assign lvl_sent8[gi] = lvl_eff[gi];
         end else begin : g_pad
            assign lvl_sent8[gi] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      enabled_in = enabled_ff;
      sent_in    = sent_ff;
      if (accept) begin
         case (op)
            OP_SUSPEND: enabled_in = 1'b0;
            OP_RESUME:  enabled_in = 1'b1;
            default:    enabled_in = enabled_ff;
         endcase
         if (frame_cmd) begin
            sent_in = lvl_sent8;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         sent_ff    <= '0;
      end else begin
         enabled_ff <= enabled_in;
         sent_ff    <= sent_in;
      end
   end

   // ---------------- command register and stepper ----------------
   logic                  cmd_valid_ff, cmd_valid_in;
   logic                  cmd_suspend_ff;
   logic [LEVEL_BITS-1:0] cmd_level_ff;
   logic [LEVEL_W-1:0]    cmd_sent_ff;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  out_load;
   seg_type               seg;

   logic rsp_valid_ff;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !cmd_valid_ff || (out_load && seg.last);

   owbl_seg_gen #(
      .LEVEL_BITS (LEVEL_BITS),
      .STEP_W     (STEP_W)
   ) u_seg_gen (
      .timing  (timing_ff),
      .suspend (cmd_suspend_ff),
      .step    (step_ff),
      .level   (cmd_level_ff),
      .seg     (seg)
   );

   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      step_in      = step_ff;
      if (accept) begin
         cmd_valid_in = emits;
         step_in      = (op == OP_RESUME) ? STEP_W'(0) : STEP_W'(FRAME_FIRST_STEP);
      end else if (cmd_valid_ff && out_load) begin
         if (seg.last) begin
            cmd_valid_in = 1'b0;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_suspend_ff <= (op == OP_SUSPEND);
         cmd_level_ff   <= lvl_eff;
         cmd_sent_ff    <= frame_cmd ? lvl_sent8 : sent_ff;
      end
   end

   // ---------------- output register ----------------
   logic               rsp_pin_ff;
   logic [DUR_W-1:0]   rsp_dur_ff;
   logic [LEVEL_W-1:0] rsp_sent_ff;
   logic               rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= cmd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && cmd_valid_ff) begin
         rsp_pin_ff  <= seg.pin;
         rsp_dur_ff  <= seg.dur;
         rsp_sent_ff <= cmd_sent_ff;
         rsp_last_ff <= seg.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pin_level   = rsp_pin_ff;
   assign rsp_duration_us = rsp_dur_ff;
   assign rsp_sent_level  = rsp_sent_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
